### design/seg_dist_pkg.sv
`default_nettype none

package seg_dist_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int COORD_FRAC_BITS = 4;
    localparam int OUT_FRAC        = 8;
    localparam int DIST_WIDTH      = 21;
    localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

    // coordinate difference, product sum, squared length
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PW  = 2 * DW;
    localparam int D2W = 2 * COORD_WIDTH + 1;

    localparam int SHIFT_UP = (OUT_FRAC > COORD_FRAC_BITS) ? OUT_FRAC - COORD_FRAC_BITS : 0;
    localparam int SHIFT_DN = (COORD_FRAC_BITS > OUT_FRAC) ? COORD_FRAC_BITS - OUT_FRAC : 0;

    // quotient (squared distance, scaled), dividend, root
    localparam int QW  = D2W + 2 * SHIFT_UP;
    localparam int NW  = 2 * D2W + 2 * SHIFT_UP;
    localparam int RW  = (QW + 1) / 2;
    localparam int XPW = 2 * RW;

    localparam int LANES = 4;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] seg_a_start_x;
        logic signed [COORD_WIDTH-1:0] seg_a_start_y;
        logic signed [COORD_WIDTH-1:0] seg_a_end_x;
        logic signed [COORD_WIDTH-1:0] seg_a_end_y;
        logic signed [COORD_WIDTH-1:0] seg_b_start_x;
        logic signed [COORD_WIDTH-1:0] seg_b_start_y;
        logic signed [COORD_WIDTH-1:0] seg_b_end_x;
        logic signed [COORD_WIDTH-1:0] seg_b_end_y;
    } seg_in_t;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] distance;
        logic                  crossing;
    } seg_out_t;

endpackage

`default_nettype wire

### design/segment_to_segment_distance.sv
// Least distance between two 2D segments with a crossing flag. One item is
// accepted per clock while the skid entry is empty; each item passes through
// the 41-stage restoring divider (one quotient bit per stage, four lanes side
// by side) and the 21-stage square root (one root bit per stage) behind four
// stages of differences, products, case selection and dividend set-up.
// An output register and a one-entry skid buffer let input continue while a
// result waits; input stalls only once the skid entry is full.
`default_nettype none

module segment_to_segment_distance
    import seg_dist_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire seg_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output seg_out_t      out_data
);

    localparam int DIV_N = QW;
    localparam int NST   = 4 + DIV_N + 2 + RW;

    typedef struct packed {
        logic signed [DW-1:0] pax;
        logic signed [DW-1:0] pay;
        logic signed [DW-1:0] pbx;
        logic signed [DW-1:0] pby;
        logic signed [DW-1:0] vx;
        logic signed [DW-1:0] vy;
    } lane_diff_t;

    typedef struct packed {
        lane_diff_t [LANES-1:0] lane;
        logic signed [DW-1:0]   rx;
        logic signed [DW-1:0]   ry;
        logic signed [DW-1:0]   qx;
        logic signed [DW-1:0]   qy;
        logic signed [DW-1:0]   wx;
        logic signed [DW-1:0]   wy;
        logic                   end_hit;
    } st1_t;

    typedef struct packed {
        logic [D2W-1:0]       len2;
        logic signed [PW-1:0] dota;
        logic signed [PW-1:0] dotb;
        logic signed [PW-1:0] cr;
        logic [D2W-1:0]       d2a;
        logic [D2W-1:0]       d2b;
    } lane_prod_t;

    typedef struct packed {
        lane_prod_t [LANES-1:0] lane;
        logic signed [PW-1:0]   dd;
        logic signed [PW-1:0]   tn;
        logic signed [PW-1:0]   un;
        logic                   degen;
        logic                   end_hit;
    } st2_t;

    typedef struct packed {
        logic           perp;
        logic [D2W-1:0] c;
        logic [D2W-1:0] len2;
        logic [D2W-1:0] d2;
    } lane_sel_t;

    typedef struct packed {
        lane_sel_t [LANES-1:0] lane;
        logic                  crossing;
    } st3_t;

    typedef struct packed {
        logic [D2W-1:0] rem;
        logic [QW-1:0]  low;
        logic [D2W-1:0] den;
        logic [QW-1:0]  q;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [LANES-1:0] lane;
        logic                  crossing;
    } div_t;

    typedef struct packed {
        logic [QW-1:0] m0;
        logic [QW-1:0] m1;
        logic          crossing;
    } min_t;

    typedef struct packed {
        logic [XPW-1:0] x;
        logic [RW+1:0]  rem;
        logic [RW-1:0]  root;
        logic           crossing;
    } sqrt_t;

    function automatic logic signed [PW-1:0] mul_s(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        logic signed [PW-1:0] ea;
        logic signed [PW-1:0] eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    function automatic logic signed [DW-1:0] dif(input logic signed [COORD_WIDTH-1:0] a,
                                                 input logic signed [COORD_WIDTH-1:0] b);
        logic signed [DW-1:0] ea;
        logic signed [DW-1:0] eb;
        ea = a;
        eb = b;
        return ea - eb;
    endfunction

    logic                  adv;
    logic [NST-1:0]        v_reg;
    st1_t                  s1_reg, s1_next;
    st2_t                  s2_reg, s2_next;
    st3_t                  s3_reg, s3_next;
    div_t                  s4_reg, s4_next;
    div_t                  div_reg  [DIV_N];
    div_t                  div_next [DIV_N];
    min_t                  min_reg, min_next;
    sqrt_t                 sq0_reg, sq0_next;
    sqrt_t                 sq_reg  [RW];
    sqrt_t                 sq_next [RW];
    seg_out_t              res_next;
    seg_out_t              out_reg, skid_reg;
    logic                  out_v_reg, skid_v_reg;

    assign adv      = !skid_v_reg;
    assign in_ready = adv;

    // stage 1: differences
    always_comb
    begin
        s1_next.lane[0] = '{pax: dif(in_data.seg_a_start_x, in_data.seg_b_start_x),
                            pay: dif(in_data.seg_a_start_y, in_data.seg_b_start_y),
                            pbx: dif(in_data.seg_a_start_x, in_data.seg_b_end_x),
                            pby: dif(in_data.seg_a_start_y, in_data.seg_b_end_y),
                            vx:  dif(in_data.seg_b_end_x, in_data.seg_b_start_x),
                            vy:  dif(in_data.seg_b_end_y, in_data.seg_b_start_y)};
        s1_next.lane[1] = '{pax: dif(in_data.seg_a_end_x, in_data.seg_b_start_x),
                            pay: dif(in_data.seg_a_end_y, in_data.seg_b_start_y),
                            pbx: dif(in_data.seg_a_end_x, in_data.seg_b_end_x),
                            pby: dif(in_data.seg_a_end_y, in_data.seg_b_end_y),
                            vx:  dif(in_data.seg_b_end_x, in_data.seg_b_start_x),
                            vy:  dif(in_data.seg_b_end_y, in_data.seg_b_start_y)};
        s1_next.lane[2] = '{pax: dif(in_data.seg_b_start_x, in_data.seg_a_start_x),
                            pay: dif(in_data.seg_b_start_y, in_data.seg_a_start_y),
                            pbx: dif(in_data.seg_b_start_x, in_data.seg_a_end_x),
                            pby: dif(in_data.seg_b_start_y, in_data.seg_a_end_y),
                            vx:  dif(in_data.seg_a_end_x, in_data.seg_a_start_x),
                            vy:  dif(in_data.seg_a_end_y, in_data.seg_a_start_y)};
        s1_next.lane[3] = '{pax: dif(in_data.seg_b_end_x, in_data.seg_a_start_x),
                            pay: dif(in_data.seg_b_end_y, in_data.seg_a_start_y),
                            pbx: dif(in_data.seg_b_end_x, in_data.seg_a_end_x),
                            pby: dif(in_data.seg_b_end_y, in_data.seg_a_end_y),
                            vx:  dif(in_data.seg_a_end_x, in_data.seg_a_start_x),
                            vy:  dif(in_data.seg_a_end_y, in_data.seg_a_start_y)};
        s1_next.rx = dif(in_data.seg_a_end_x, in_data.seg_a_start_x);
        s1_next.ry = dif(in_data.seg_a_end_y, in_data.seg_a_start_y);
        s1_next.qx = dif(in_data.seg_b_end_x, in_data.seg_b_start_x);
        s1_next.qy = dif(in_data.seg_b_end_y, in_data.seg_b_start_y);
        s1_next.wx = dif(in_data.seg_b_start_x, in_data.seg_a_start_x);
        s1_next.wy = dif(in_data.seg_b_start_y, in_data.seg_a_start_y);
        s1_next.end_hit =
            (in_data.seg_a_start_x == in_data.seg_b_start_x &&
             in_data.seg_a_start_y == in_data.seg_b_start_y) ||
            (in_data.seg_a_start_x == in_data.seg_b_end_x &&
             in_data.seg_a_start_y == in_data.seg_b_end_y) ||
            (in_data.seg_a_end_x == in_data.seg_b_start_x &&
             in_data.seg_a_end_y == in_data.seg_b_start_y) ||
            (in_data.seg_a_end_x == in_data.seg_b_end_x &&
             in_data.seg_a_end_y == in_data.seg_b_end_y);
    end

    // stage 2: dot and cross products
    always_comb
    begin
        logic signed [PW-1:0] t;
        for (int l = 0; l < LANES; l++)
        begin
            t = mul_s(s1_reg.lane[l].vx, s1_reg.lane[l].vx)
              + mul_s(s1_reg.lane[l].vy, s1_reg.lane[l].vy);
            s2_next.lane[l].len2 = t[D2W-1:0];
            s2_next.lane[l].dota = mul_s(s1_reg.lane[l].pax, s1_reg.lane[l].vx)
                                 + mul_s(s1_reg.lane[l].pay, s1_reg.lane[l].vy);
            s2_next.lane[l].dotb = mul_s(s1_reg.lane[l].pbx, s1_reg.lane[l].vx)
                                 + mul_s(s1_reg.lane[l].pby, s1_reg.lane[l].vy);
            s2_next.lane[l].cr   = mul_s(s1_reg.lane[l].pax, s1_reg.lane[l].vy)
                                 - mul_s(s1_reg.lane[l].pay, s1_reg.lane[l].vx);
            t = mul_s(s1_reg.lane[l].pax, s1_reg.lane[l].pax)
              + mul_s(s1_reg.lane[l].pay, s1_reg.lane[l].pay);
            s2_next.lane[l].d2a = t[D2W-1:0];
            t = mul_s(s1_reg.lane[l].pbx, s1_reg.lane[l].pbx)
              + mul_s(s1_reg.lane[l].pby, s1_reg.lane[l].pby);
            s2_next.lane[l].d2b = t[D2W-1:0];
        end
        s2_next.dd = mul_s(s1_reg.rx, s1_reg.qy) - mul_s(s1_reg.ry, s1_reg.qx);
        s2_next.tn = mul_s(s1_reg.wx, s1_reg.qy) - mul_s(s1_reg.wy, s1_reg.qx);
        s2_next.un = mul_s(s1_reg.wx, s1_reg.ry) - mul_s(s1_reg.wy, s1_reg.rx);
        s2_next.degen = (s1_reg.rx == '0 && s1_reg.ry == '0) ||
                        (s1_reg.qx == '0 && s1_reg.qy == '0);
        s2_next.end_hit = s1_reg.end_hit;
    end

    // stage 3: nearer end point or perpendicular, crossing decision
    always_comb
    begin
        logic signed [PW-1:0] mag;
        for (int l = 0; l < LANES; l++)
        begin
            mag = s2_reg.lane[l].cr[PW-1] ? -s2_reg.lane[l].cr : s2_reg.lane[l].cr;
            s3_next.lane[l].c    = mag[D2W-1:0];
            s3_next.lane[l].len2 = s2_reg.lane[l].len2;
            priority if (s2_reg.lane[l].len2 == '0 || s2_reg.lane[l].dota < 0)
            begin
                s3_next.lane[l].perp = 1'b0;
                s3_next.lane[l].d2   = s2_reg.lane[l].d2a;
            end
            else if (s2_reg.lane[l].dotb > 0)
            begin
                s3_next.lane[l].perp = 1'b0;
                s3_next.lane[l].d2   = s2_reg.lane[l].d2b;
            end
            else
            begin
                s3_next.lane[l].perp = 1'b1;
                s3_next.lane[l].d2   = s2_reg.lane[l].d2a;
            end
        end
        priority if (s2_reg.degen)
            s3_next.crossing = s2_reg.end_hit;
        else if (s2_reg.dd == '0)
            s3_next.crossing = 1'b0;
        else if (s2_reg.dd > 0)
            s3_next.crossing = s2_reg.tn >= 0 && s2_reg.tn <= s2_reg.dd &&
                               s2_reg.un >= 0 && s2_reg.un <= s2_reg.dd;
        else
            s3_next.crossing = s2_reg.tn <= 0 && s2_reg.tn >= s2_reg.dd &&
                               s2_reg.un <= 0 && s2_reg.un >= s2_reg.dd;
    end

    // stage 4: dividend and divisor; an end point case divides by one
    always_comb
    begin
        logic [NW-1:0] num;
        for (int l = 0; l < LANES; l++)
        begin
            if (s3_reg.lane[l].perp)
            begin
                num = (NW'(s3_reg.lane[l].c) * NW'(s3_reg.lane[l].c)) << (2 * SHIFT_UP);
                s4_next.lane[l].den = s3_reg.lane[l].len2;
            end
            else
            begin
                num = NW'(s3_reg.lane[l].d2) << (2 * SHIFT_UP);
                s4_next.lane[l].den = D2W'(1);
            end
            s4_next.lane[l].rem = num[NW-1:QW];
            s4_next.lane[l].low = num[QW-1:0];
            s4_next.lane[l].q   = '0;
        end
        s4_next.crossing = s3_reg.crossing;
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        div_t src;
        if (k == 0)
        begin : g_first
            assign src = s4_reg;
        end
        else
        begin : g_rest
            assign src = div_reg[k-1];
        end

        always_comb
        begin
            logic [D2W:0] t;
            div_next[k] = src;
            for (int l = 0; l < LANES; l++)
            begin
                t = {src.lane[l].rem, src.lane[l].low[QW-1-k]};
                if (t >= {1'b0, src.lane[l].den})
                begin
                    t = t - {1'b0, src.lane[l].den};
                    div_next[k].lane[l].q[QW-1-k] = 1'b1;
                end
                div_next[k].lane[l].rem = t[D2W-1:0];
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0] a;
        logic [QW-1:0] b;
        a = div_reg[DIV_N-1].lane[0].q;
        b = div_reg[DIV_N-1].lane[1].q;
        min_next.m0 = (b < a) ? b : a;
        a = div_reg[DIV_N-1].lane[2].q;
        b = div_reg[DIV_N-1].lane[3].q;
        min_next.m1 = (b < a) ? b : a;
        min_next.crossing = div_reg[DIV_N-1].crossing;
    end

    always_comb
    begin
        sq0_next.x        = XPW'((min_reg.m1 < min_reg.m0) ? min_reg.m1 : min_reg.m0);
        sq0_next.rem      = '0;
        sq0_next.root     = '0;
        sq0_next.crossing = min_reg.crossing;
    end

    // integer square root, one root bit per stage
    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        sqrt_t src;
        if (j == 0)
        begin : g_first
            assign src = sq0_reg;
        end
        else
        begin : g_rest
            assign src = sq_reg[j-1];
        end

        always_comb
        begin
            logic [RW+3:0] t;
            logic [RW+3:0] trial;
            sq_next[j] = src;
            t     = {src.rem, src.x[2*(RW-1-j)+1 -: 2]};
            trial = (RW+4)'({src.root, 2'b01});
            if (t >= trial)
            begin
                t = t - trial;
                sq_next[j].root = {src.root[RW-2:0], 1'b1};
            end
            else
            begin
                sq_next[j].root = {src.root[RW-2:0], 1'b0};
            end
            sq_next[j].rem = t[RW+1:0];
        end
    end

    always_comb
    begin
        logic [RW-1:0]            rs;
        logic [RW+DIST_WIDTH-1:0] ext;
        rs  = sq_reg[RW-1].root >> SHIFT_DN;
        ext = (RW+DIST_WIDTH)'(rs);
        res_next.crossing = sq_reg[RW-1].crossing;
        if (sq_reg[RW-1].crossing)
            res_next.distance = '0;
        else if (ext > (RW+DIST_WIDTH)'(DIST_MAX))
            res_next.distance = DIST_MAX;
        else
            res_next.distance = ext[DIST_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            min_reg <= min_next;
            sq0_reg <= sq0_next;
            for (int k = 0; k < DIV_N; k++)
                div_reg[k] <= div_next[k];
            for (int j = 0; j < RW; j++)
                sq_reg[j] <= sq_next[j];
        end
    end

    // output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_ready)
                skid_v_reg <= 1'b0;
        end
        else if (v_reg[NST-1])
        begin
            if (out_v_reg && !out_ready)
                skid_v_reg <= 1'b1;
            else
                out_v_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_ready)
                out_reg <= skid_reg;
        end
        else if (v_reg[NST-1])
        begin
            if (out_v_reg && !out_ready)
                skid_reg <= res_next;
            else
                out_reg <= res_next;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### sim/tb_segment_to_segment_distance.sv
`default_nettype none

module tb_segment_to_segment_distance;
    import seg_dist_pkg::*;

    typedef logic [127:0] u128_t;

    class segment_distance_board;
        seg_out_t pending[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function longint unsigned root_floor(u128_t x);
            u128_t r;
            u128_t b;
            r = 0;
            b = u128_t'(1) << 126;
            while (b > x)
                b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r[63:0]);
        endfunction

        static function longint unsigned end_dist(longint dx, longint dy);
            u128_t d2;
            d2 = u128_t'(dx * dx + dy * dy);
            return root_floor(d2 << (2 * SHIFT_UP)) >> SHIFT_DN;
        endfunction

        static function longint unsigned point_to_seg(longint px, longint py, longint ax,
                                                      longint ay, longint bx, longint by);
            longint vx;
            longint vy;
            longint c;
            u128_t  n;
            u128_t  len2;
            vx = bx - ax;
            vy = by - ay;
            if (vx == 0 && vy == 0)
                return end_dist(px - ax, py - ay);
            if ((px - ax) * vx + (py - ay) * vy < 0)
                return end_dist(px - ax, py - ay);
            if ((px - bx) * (-vx) + (py - by) * (-vy) < 0)
                return end_dist(px - bx, py - by);
            len2 = u128_t'(vx * vx + vy * vy);
            c = (px - ax) * vy - (py - ay) * vx;
            if (c < 0)
                c = -c;
            n = (u128_t'(c) * u128_t'(c)) << (2 * SHIFT_UP);
            return root_floor(n / len2) >> SHIFT_DN;
        endfunction

        static function seg_out_t predict(seg_in_t s);
            longint   p[8];
            longint   rx, ry, qx, qy, wx, wy, d, tn, un;
            longint unsigned best;
            longint unsigned v;
            seg_out_t r;
            bit       hit;
            p[0] = s.seg_a_start_x; p[1] = s.seg_a_start_y;
            p[2] = s.seg_a_end_x;   p[3] = s.seg_a_end_y;
            p[4] = s.seg_b_start_x; p[5] = s.seg_b_start_y;
            p[6] = s.seg_b_end_x;   p[7] = s.seg_b_end_y;
            rx = p[2] - p[0]; ry = p[3] - p[1];
            qx = p[6] - p[4]; qy = p[7] - p[5];
            wx = p[4] - p[0]; wy = p[5] - p[1];
            if ((rx == 0 && ry == 0) || (qx == 0 && qy == 0))
                hit = (p[0] == p[4] && p[1] == p[5]) || (p[0] == p[6] && p[1] == p[7])
                   || (p[2] == p[4] && p[3] == p[5]) || (p[2] == p[6] && p[3] == p[7]);
            else
            begin
                d = rx * qy - ry * qx;
                tn = wx * qy - wy * qx;
                un = wx * ry - wy * rx;
                if (d < 0)
                begin
                    d = -d;
                    tn = -tn;
                    un = -un;
                end
                hit = d != 0 && tn >= 0 && tn <= d && un >= 0 && un <= d;
            end
            r.crossing = hit;
            if (hit)
            begin
                r.distance = '0;
                return r;
            end
            best = point_to_seg(p[0], p[1], p[4], p[5], p[6], p[7]);
            v = point_to_seg(p[2], p[3], p[4], p[5], p[6], p[7]);
            if (v < best) best = v;
            v = point_to_seg(p[4], p[5], p[0], p[1], p[2], p[3]);
            if (v < best) best = v;
            v = point_to_seg(p[6], p[7], p[0], p[1], p[2], p[3]);
            if (v < best) best = v;
            if (best > DIST_MAX) best = DIST_MAX;
            r.distance = best[DIST_WIDTH-1:0];
            return r;
        endfunction

        function void note_pair(seg_in_t s);
            pending.push_back(predict(s));
        endfunction

        function void check_result(seg_out_t got);
            seg_out_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result distance=%0d crossing=%0d", got.distance, got.crossing);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance)
            begin
                $error("distance: expected %0d, got %0d", want.distance, got.distance);
                mismatches++;
            end
            if (got.crossing !== want.crossing)
            begin
                $error("crossing: expected %0d, got %0d", want.crossing, got.crossing);
                mismatches++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    seg_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    seg_out_t out_data;

    segment_distance_board board;
    bit       calm;

    segment_to_segment_distance uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("tb_segment_to_segment_distance: errors");
        $finish;
    end

    function automatic logic [15:0] pick_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 400)) - 16'd200;
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 4000)) - 16'd2000;
        endcase
    endfunction

    function automatic seg_in_t random_pair();
        seg_in_t s;
        int      mode;
        int      kind;
        mode = $urandom_range(0, 3);
        s.seg_a_start_x = pick_coord(mode);
        s.seg_a_start_y = pick_coord(mode);
        s.seg_a_end_x   = pick_coord(mode);
        s.seg_a_end_y   = pick_coord(mode);
        s.seg_b_start_x = pick_coord(mode);
        s.seg_b_start_y = pick_coord(mode);
        s.seg_b_end_x   = pick_coord(mode);
        s.seg_b_end_y   = pick_coord(mode);
        kind = $urandom_range(0, 9);
        // degenerate, shared end point, parallel and collinear shapes
        if (kind == 0)
        begin
            s.seg_a_end_x = s.seg_a_start_x;
            s.seg_a_end_y = s.seg_a_start_y;
        end
        else if (kind == 1)
        begin
            s.seg_b_start_x = s.seg_a_end_x;
            s.seg_b_start_y = s.seg_a_end_y;
        end
        else if (kind == 2)
        begin
            s.seg_b_end_x = s.seg_b_start_x + (s.seg_a_end_x - s.seg_a_start_x);
            s.seg_b_end_y = s.seg_b_start_y + (s.seg_a_end_y - s.seg_a_start_y);
        end
        else if (kind == 3)
        begin
            s.seg_a_start_y = 16'd10;
            s.seg_a_end_y   = 16'd10;
            s.seg_b_start_y = 16'd10;
            s.seg_b_end_y   = 16'd10;
        end
        else if (kind == 4)
        begin
            s.seg_b_end_x = s.seg_b_start_x;
            s.seg_b_end_y = s.seg_b_start_y;
        end
        return s;
    endfunction

    task automatic send_pair(seg_in_t s);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_pair(s);
        @(negedge clk);
    endtask

    function automatic seg_in_t make_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        seg_in_t s;
        s.seg_a_start_x = 16'(ax); s.seg_a_start_y = 16'(ay);
        s.seg_a_end_x   = 16'(bx); s.seg_a_end_y   = 16'(by);
        s.seg_b_start_x = 16'(cx); s.seg_b_start_y = 16'(cy);
        s.seg_b_end_x   = 16'(dx); s.seg_b_end_y   = 16'(dy);
        return s;
    endfunction

    initial
    begin
        board     = new();
        calm      = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0));
        send_pair(make_pair(0, 0, 160, 0, 160, 0, 320, 80));
        send_pair(make_pair(0, 0, 160, 0, 0, 32, 160, 32));
        send_pair(make_pair(0, 0, 160, 0, 80, 0, 320, 0));
        send_pair(make_pair(0, 0, 160, 0, 200, 0, 320, 0));
        send_pair(make_pair(5, 5, 5, 5, 5, 5, 100, 9));
        send_pair(make_pair(5, 5, 5, 5, 40, -7, 40, -7));
        send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
        send_pair(make_pair(0, 0, 160, 0, 80, 48, 80, 48));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
        send_pair(make_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, 32767, -32768, 32767, 32767, -32768, 32767, -32768));
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767));
        send_pair(make_pair(0, 0, 100, 0, 50, 1, 50, 100));
        send_pair(make_pair(0, 0, 100, 0, 50, 0, 50, 100));
        send_pair(make_pair(0, 0, 100, 0, 150, 3, 170, 90));
        send_pair(make_pair(-1, -1, -1, -1, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, 0, 0, -1, -1, -1, -1));

        for (int i = 0; i < 630; i++)
        begin
            if (i == 540)
                calm = 1'b1;
            send_pair(random_pair());
        end
        in_valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.mismatches == 0)
            $display("tb_segment_to_segment_distance: clean");
        else
            $display("tb_segment_to_segment_distance: errors");
        $finish;
    end

    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 18);
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(out_data);
    end

endmodule

`default_nettype wire
